// ===== rtl/core/gsbt_pkg.sv =====
// Package with the word types, codes and reset values of the gear selector.
`timescale 1ns / 1ps
`default_nettype none

package gsbt_pkg;

  localparam int unsigned TimerBitsDefault = 16;

  // Gear codes.
  localparam logic [2:0] GearPark   = 3'd0;
  localparam logic [2:0] GearRev    = 3'd1;
  localparam logic [2:0] GearFirst  = 3'd2;
  localparam logic [2:0] GearSecond = 3'd3;
  localparam logic [2:0] GearThird  = 3'd4;
  localparam logic [2:0] GearEco    = 3'd5;
  localparam logic [2:0] GearBoost  = 3'd6;
  localparam logic [2:0] GearNone   = 3'd7;

  // Command codes.
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncUp    = 2'd1;
  localparam logic [1:0] FuncDown  = 2'd2;
  localparam logic [1:0] FuncSet   = 2'd3;

  // Refusal codes.
  localparam logic [2:0] RefNone     = 3'd0;
  localparam logic [2:0] RefCooldown = 3'd1;
  localparam logic [2:0] RefVoltage  = 3'd2;
  localparam logic [2:0] RefCurrent  = 3'd3;
  localparam logic [2:0] RefAtEnd    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CfgCooldown  = 3'd0;
  localparam logic [2:0] CfgBoostTmo  = 3'd1;
  localparam logic [2:0] CfgMinVolt   = 3'd2;
  localparam logic [2:0] CfgMaxCurr   = 3'd3;
  localparam logic [2:0] CfgCheckEn   = 3'd4;

  // Configuration reset values.
  localparam logic [15:0]        CooldownRst = 16'd500;
  localparam logic [15:0]        BoostTmoRst = 16'd10000;
  localparam logic [14:0]        MinVoltRst  = 15'd5800;
  localparam logic signed [15:0] MaxCurrRst  = 16'sd1800;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         target_gear;
    logic [14:0]        battery_voltage_cv;
    logic signed [15:0] battery_current_ca;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  gear;
    logic        changed;
    logic [2:0]  refusal;
    logic [15:0] boost_left_ms;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/gear_selector_with_boost_timeout.sv =====
// Gear selector with shift cooldown, boost power checks and boost timeout.
//
//   channel   signals                                 moves
//   in        in_valid_i / in_ready_o / in_word_i     one command or tick word
//   out       out_valid_o / out_ready_i / out_word_o  one status word per input
//   cfg       cfg_we_i / cfg_idx_i / cfg_data_i       register write, no wait
//
// Each accepted word updates the gear state in the cycle it is accepted and its
// status word is registered; one word per cycle flows while output is read.
// A result register plus a skid register let input be taken while a status
// word waits; input stalls only when both hold unread words.
// Reset puts the gear in park, clears both timers and loads the register
// defaults.
`timescale 1ns / 1ps
`default_nettype none

module gear_selector_with_boost_timeout
  import gsbt_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  // Comparisons run wide enough for both the timers and the 16 bit registers.
  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [15:0]        cooldown_q;
  logic [15:0]        boost_tmo_q;
  logic [14:0]        min_volt_q;
  logic signed [15:0] max_curr_q;
  logic               check_en_q;

  logic [2:0]            gear_q, gear_d;
  logic [TIMER_BITS-1:0] since_q, since_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;

  out_word_t out_q, out_d, skid_q;
  logic      out_vld_q, skid_vld_q;

  logic push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q  <= CooldownRst;
      boost_tmo_q <= BoostTmoRst;
      min_volt_q  <= MinVoltRst;
      max_curr_q  <= MaxCurrRst;
      check_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCooldown: cooldown_q  <= cfg_data_i;
        CfgBoostTmo: boost_tmo_q <= cfg_data_i;
        CfgMinVolt:  min_volt_q  <= cfg_data_i[14:0];
        CfgMaxCurr:  max_curr_q  <= cfg_data_i;
        CfgCheckEn:  check_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Gear state update for the word being accepted.
  logic [TIMER_BITS-1:0] since_inc, elapsed_inc;
  logic [2:0]            next_gear;
  logic                  at_end;
  logic [2:0]            refusal;
  logic                  changed;
  logic [CmpW-1:0]       tmo_ext, el_ext;

  assign since_inc   = (&since_q) ? since_q : since_q + 1'b1;
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign tmo_ext     = CmpW'(boost_tmo_q);

  always_comb begin
    next_gear = GearNone;
    at_end    = 1'b0;
    case (in_word_i.func)
      FuncUp: begin
        case (gear_q)
          GearPark:   next_gear = GearFirst;
          GearRev:    next_gear = GearPark;
          GearFirst:  next_gear = GearSecond;
          GearSecond: next_gear = GearThird;
          GearThird:  next_gear = GearBoost;
          GearEco:    next_gear = GearFirst;
          default:    at_end = 1'b1;
        endcase
      end
      FuncDown: begin
        case (gear_q)
          GearPark:   next_gear = GearRev;
          GearFirst:  next_gear = GearEco;
          GearSecond: next_gear = GearFirst;
          GearThird:  next_gear = GearSecond;
          GearEco:    next_gear = GearPark;
          GearBoost:  next_gear = GearThird;
          default:    at_end = 1'b1;
        endcase
      end
      FuncSet: next_gear = in_word_i.target_gear;
      default: ;
    endcase
  end

  always_comb begin
    gear_d    = gear_q;
    since_d   = since_q;
    elapsed_d = elapsed_q;
    refusal   = RefNone;
    changed   = 1'b0;
    if (in_word_i.func == FuncTick) begin
      since_d = since_inc;
      if (gear_q == GearBoost) begin
        elapsed_d = elapsed_inc;
        // Boost has run out: drop to third without a cooldown check.
        if (CmpW'(elapsed_inc) > tmo_ext) begin
          gear_d  = GearThird;
          since_d = '0;
          changed = 1'b1;
        end
      end
    end else if (at_end) begin
      refusal = RefAtEnd;
    end else if (next_gear != GearNone) begin
      if (CmpW'(since_q) < CmpW'(cooldown_q)) begin
        refusal = RefCooldown;
      end else if (next_gear == GearBoost && check_en_q &&
                   in_word_i.battery_voltage_cv < min_volt_q) begin
        refusal = RefVoltage;
      end else if (next_gear == GearBoost && check_en_q &&
                   in_word_i.battery_current_ca > max_curr_q) begin
        refusal = RefCurrent;
      end else begin
        gear_d  = next_gear;
        since_d = '0;
        changed = 1'b1;
        if (next_gear == GearBoost) begin
          elapsed_d = '0;
        end
      end
    end
  end

  assign el_ext = CmpW'(elapsed_d);

  always_comb begin
    out_d.gear          = gear_d;
    out_d.changed       = changed;
    out_d.refusal       = refusal;
    out_d.boost_left_ms = '0;
    if (gear_d == GearBoost && el_ext < tmo_ext) begin
      out_d.boost_left_ms = 16'(tmo_ext - el_ext);
    end
  end

  // Output register with a skid register behind it.
  assign in_ready_o  = !skid_vld_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_vld_q && out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q     <= GearPark;
      since_q    <= '0;
      elapsed_q  <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (push) begin
        gear_q    <= gear_d;
        since_q   <= since_d;
        elapsed_q <= elapsed_d;
      end
      if (!out_vld_q || pop) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= push;
        end
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= out_d;
      end
    end else if (push) begin
      skid_q <= out_d;
    end
  end

endmodule

`default_nettype wire
